// File: sv/rconv_pkg.sv
// ----------------------------------------------------------------------------
// rconv_pkg
// Shared types and constants of the radix converter: transfer payloads,
// register indexes, buffer depth and default parameter values.
// ----------------------------------------------------------------------------
package rconv_pkg;

  // default parameter values
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_BASE_DEF   = 36;

  // fixed field widths
  localparam int DIGIT_W    = 6;
  localparam int BASE_REG_W = 6;
  localparam int CFG_IDX_W  = 1;

  // digit buffer: depth, address and count widths
  localparam int OUT_DEPTH = 32;
  localparam int BUF_AW    = $clog2(OUT_DEPTH);
  localparam int COUNT_W   = $clog2(OUT_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 1'b1;

  // register reset values
  localparam logic [BASE_REG_W-1:0] SOURCE_BASE_RST = 6'd10;
  localparam logic [BASE_REG_W-1:0] TARGET_BASE_RST = 6'd2;

  // input transfer payload
  typedef struct packed {
    logic [DIGIT_W-1:0] digit_value;
    logic               is_final_digit;
  } digit_item_t;

  // output transfer payload
  typedef struct packed {
    logic [DIGIT_W-1:0] result_digit;
    logic               result_last;
  } result_item_t;

  // status of a multi-cycle unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: sv/rconv_ram.sv
// ----------------------------------------------------------------------------
// rconv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rconv_ram #(
  parameter int WIDTH = rconv_pkg::DIGIT_W,
  parameter int DEPTH = rconv_pkg::OUT_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/rconv_mac.sv
// ----------------------------------------------------------------------------
// rconv_mac
// Accumulator update acc = acc * base + digit, done as a shift-add over the
// base bits, lsb first, one base bit per cycle. Wraps modulo 2^VALUE_BITS.
// ----------------------------------------------------------------------------
module rconv_mac #(
  parameter int VALUE_BITS = rconv_pkg::VALUE_BITS_DEF,
  parameter int BASE_W     = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        clear,
  input  logic [BASE_W-1:0]           base,
  input  logic [rconv_pkg::DIGIT_W-1:0] digit,
  output logic [VALUE_BITS-1:0]       acc,
  output rconv_pkg::unit_stat_t       stat
);

  logic                  busy;
  logic [VALUE_BITS-1:0] sum;
  logic [VALUE_BITS-1:0] mcand;
  logic [BASE_W-1:0]     mplier;
  logic                  finish;

  // all base bits consumed
  assign finish = busy && (mplier == '0);

  assign stat.busy = busy;
  assign stat.done = finish;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      acc  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (clear) begin
        acc <= '0;
      end else if (finish) begin
        acc <= sum;
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sum    <= VALUE_BITS'(digit);
      mcand  <= acc;
      mplier <= base;
    end else if (busy && !finish) begin
      if (mplier[0]) begin
        sum <= sum + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

// File: sv/rconv_div.sv
// ----------------------------------------------------------------------------
// rconv_div
// Repeated division by the target base, restoring, one quotient bit per
// cycle. Each finished division writes its remainder (a target digit, least
// significant first) to the digit buffer. Stops on a zero quotient or a full
// buffer.
// ----------------------------------------------------------------------------
module rconv_div #(
  parameter int VALUE_BITS = rconv_pkg::VALUE_BITS_DEF,
  parameter int BASE_W     = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [VALUE_BITS-1:0]         value,
  input  logic [BASE_W-1:0]             base,
  output logic                          wr_en,
  output logic [rconv_pkg::BUF_AW-1:0]  wr_addr,
  output logic [rconv_pkg::DIGIT_W-1:0] wr_data,
  output logic [rconv_pkg::BUF_AW-1:0]  last_addr,
  output rconv_pkg::unit_stat_t         stat
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                           busy;
  logic [VALUE_BITS-1:0]          quot;
  logic [BASE_W-1:0]              rem;
  logic [BASE_W-1:0]              divisor;
  logic [CNT_W-1:0]               bit_cnt;
  logic [rconv_pkg::COUNT_W-1:0]  n_digits;

  logic [BASE_W:0]                trial;
  logic                           fits;
  logic [BASE_W-1:0]              rem_next;
  logic [VALUE_BITS-1:0]          quot_next;
  logic                           last_bit;
  logic                           finish;

  // one restoring step
  assign trial     = {rem, quot[VALUE_BITS-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign rem_next  = fits ? BASE_W'(trial - {1'b0, divisor}) : trial[BASE_W-1:0];
  assign quot_next = {quot[VALUE_BITS-2:0], fits};
  assign last_bit  = bit_cnt == CNT_W'(VALUE_BITS - 1);

  // digit write at the end of each division
  assign wr_en   = busy && last_bit;
  assign wr_addr = n_digits[rconv_pkg::BUF_AW-1:0];
  assign wr_data = rconv_pkg::DIGIT_W'(rem_next);
  assign finish  = wr_en && ((quot_next == '0) ||
                   (n_digits == rconv_pkg::COUNT_W'(rconv_pkg::OUT_DEPTH - 1)));

  assign last_addr = n_digits[rconv_pkg::BUF_AW-1:0];
  assign stat.busy = busy;
  assign stat.done = finish;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quot     <= value;
      rem      <= '0;
      divisor  <= base;
      bit_cnt  <= '0;
      n_digits <= '0;
    end else if (busy) begin
      quot <= quot_next;
      if (last_bit) begin
        rem      <= '0;
        bit_cnt  <= '0;
        n_digits <= n_digits + 1'b1;
      end else begin
        rem     <= rem_next;
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

endmodule

// File: sv/radix_converter_core.sv
// ----------------------------------------------------------------------------
// radix_converter_core
// Converts an unsigned number given as source-base digits (msb first) into
// target-base digits (msb first), last digit flagged.
//
//   channel | dir | handshake                  | payload
//   digit   | in  | digit_valid / digit_ready  | digit  (digit_item_t)
//   result  | out | result_valid / result_ready| result (result_item_t)
//   cfg     | in  | cfg_wr_en                  | cfg_index, cfg_wdata
//
// Each digit is accumulated by the shift-add accumulator. A final digit then
// adds a setup state (S_CONV) and the bit-serial divider for each target
// digit, and then for each emitted digit a read of the buffer read port
// (S_RD) before its result transfer (S_OUT).
// One number is handled at a time; digit_ready is low while a digit
// accumulates, and after a final digit until the last result transfer.
// A stalled result_ready holds the sequencer.
// Reset clears control state and the accumulator; the digit buffer needs no
// clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
module radix_converter_core #(
  parameter int VALUE_BITS = rconv_pkg::VALUE_BITS_DEF,
  parameter int MAX_BASE   = rconv_pkg::MAX_BASE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               digit_valid,
  output logic                               digit_ready,
  input  rconv_pkg::digit_item_t             digit,
  output logic                               result_valid,
  input  logic                               result_ready,
  output rconv_pkg::result_item_t            result,
  input  logic                               cfg_wr_en,
  input  logic [rconv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rconv_pkg::BASE_REG_W-1:0]   cfg_wdata
);

  localparam int BASE_W = $clog2(MAX_BASE + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAC  = 6'b000010,
    S_CONV = 6'b000100,
    S_DIV  = 6'b001000,
    S_RD   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                             state;
  state_t                             state_next;
  logic [rconv_pkg::BASE_REG_W-1:0]   source_base;
  logic [rconv_pkg::BASE_REG_W-1:0]   target_base;
  logic                               final_seen;
  logic [rconv_pkg::BUF_AW-1:0]       idx;

  logic                               digit_xfer;
  logic                               result_xfer;
  logic [VALUE_BITS-1:0]              mac_acc;
  rconv_pkg::unit_stat_t              mac_stat;
  rconv_pkg::unit_stat_t              div_stat;
  logic                               buf_wr_en;
  logic [rconv_pkg::BUF_AW-1:0]       buf_wr_addr;
  logic [rconv_pkg::DIGIT_W-1:0]      buf_wr_data;
  logic [rconv_pkg::DIGIT_W-1:0]      buf_rd_data;
  logic [rconv_pkg::BUF_AW-1:0]       div_last_addr;

  // out-of-range bases act as the nearest legal base
  function automatic logic [BASE_W-1:0] clamp_base(input logic [rconv_pkg::BASE_REG_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < 2) begin
      r = BASE_W'(2);
    end else if (b > MAX_BASE) begin
      r = BASE_W'(MAX_BASE);
    end else begin
      r = BASE_W'(b);
    end
    return r;
  endfunction

  assign digit_ready  = state == S_IDLE;
  assign digit_xfer   = digit_valid && digit_ready;
  assign result_valid = state == S_OUT;
  assign result_xfer  = result_valid && result_ready;

  assign result.result_digit = buf_rd_data;
  assign result.result_last  = idx == '0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= rconv_pkg::SOURCE_BASE_RST;
      target_base <= rconv_pkg::TARGET_BASE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rconv_pkg::REG_SOURCE_BASE: source_base <= cfg_wdata;
        rconv_pkg::REG_TARGET_BASE: target_base <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (digit_xfer) state_next = S_MAC;
      S_MAC: begin
        if (mac_stat.done) begin
          state_next = final_seen ? S_CONV : S_IDLE;
        end
      end
      S_CONV: state_next = S_DIV;
      S_DIV:  if (div_stat.done) state_next = S_RD;
      S_RD:   state_next = S_OUT;
      S_OUT: begin
        if (result_xfer) begin
          state_next = (idx == '0) ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // final flag and buffer read index
  always_ff @(posedge clk) begin
    if (digit_xfer) begin
      final_seen <= digit.is_final_digit;
    end
    if (div_stat.done) begin
      idx <= div_last_addr;
    end else if (result_xfer) begin
      idx <= idx - 1'b1;
    end
  end

  // accumulator
  rconv_mac #(
    .VALUE_BITS (VALUE_BITS),
    .BASE_W     (BASE_W)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (digit_xfer),
    .clear (state == S_CONV),
    .base  (clamp_base(source_base)),
    .digit (digit.digit_value),
    .acc   (mac_acc),
    .stat  (mac_stat)
  );

  // repeated divider
  rconv_div #(
    .VALUE_BITS (VALUE_BITS),
    .BASE_W     (BASE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_CONV),
    .value     (mac_acc),
    .base      (clamp_base(target_base)),
    .wr_en     (buf_wr_en),
    .wr_addr   (buf_wr_addr),
    .wr_data   (buf_wr_data),
    .last_addr (div_last_addr),
    .stat      (div_stat)
  );

  // digit buffer
  rconv_ram #(
    .WIDTH (rconv_pkg::DIGIT_W),
    .DEPTH (rconv_pkg::OUT_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (buf_wr_addr),
    .wr_data (buf_wr_data),
    .rd_addr (idx),
    .rd_data (buf_rd_data)
  );

  // accumulator is cleared once the divider has taken the value
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> mac_acc == '0)
    else $error("accumulator not cleared during conversion");

  // accumulator and divider never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mac_stat.busy && div_stat.busy))
    else $error("accumulator and divider both busy");

  // the last result transfer frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_xfer && result.result_last) |=> digit_ready)
    else $error("input not ready after last result");

  // no result pending while a digit can be taken
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(digit_ready && result_valid))
    else $error("digit ready while result pending");

endmodule
